// File: rtl/core/drrip_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drrip_pkg
// Shared codes and constants for the dead-block DRRIP replacement engine.
// ----------------------------------------------------------------------------
package drrip_pkg;

	localparam logic       ACT_VICTIM = 1'b0;
	localparam logic       ACT_UPDATE = 1'b1;

	localparam logic [1:0] RRV_MAX    = 2'd3;
	localparam logic [1:0] RRV_NEAR   = 2'd2;
	localparam logic [1:0] RRV_HIT    = 2'd0;

	localparam logic [9:0] SEL_MID    = 10'd512;
	localparam logic [9:0] SEL_MAX    = 10'd1023;

	localparam logic [1:0] CNT_MAX    = 2'd3;
	localparam logic [1:0] CNT_STREAM = 2'd2;

	typedef struct packed {
		logic [63:0] prev_address;
		logic [63:0] prev_stride;
		logic [1:0]  stream_count;
	} set_rec_t;

endpackage
`default_nettype wire

// File: rtl/core/drrip_stream_dead_block_replacement_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drrip_stream_dead_block_replacement_top
// Replacement engine: per-line re-reference values and dead marks, per-set
// stride-stream detection and set dueling with a saturating policy selector.
// ----------------------------------------------------------------------------
// Each beat reads the set's line row and stream record from synchronous
// memory in the accept cycle; both are modified and written back once the
// result register is free, which also loads that register. A stalled result
// holds the beat in work. The block takes no beat while one is in work. After
// reset a clearing pass writes every set once, during which no input beat is
// taken.
module drrip_stream_dead_block_replacement_top #(
	parameter int NUM_SETS     = 2048,
	parameter int NUM_WAYS     = 16,
	parameter int LEADER_COUNT = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        action,
	input  wire logic [10:0] set_index,
	input  wire logic [3:0]  way,
	input  wire logic [63:0] address,
	input  wire logic        hit,
	input  wire logic [4:0]  random_draw,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       victim_way,
	output logic             stream_detected
);
	import drrip_pkg::*;

	localparam int SW = $clog2(NUM_SETS);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_WORK  = 2'd2;

	typedef logic [NUM_WAYS-1:0][1:0] rrv_row_t;
	typedef logic [NUM_WAYS-1:0]      dead_row_t;

	rrv_row_t  rrv_mem  [NUM_SETS];
	dead_row_t dead_mem [NUM_SETS];
	set_rec_t  set_mem  [NUM_SETS];

	logic [1:0]    state_q;
	logic [SW-1:0] clr_q;
	logic [9:0]    sel_q;

	rrv_row_t  rrv_s1;
	dead_row_t dead_s1;
	set_rec_t  rec_s1;
	logic          act_s1;
	logic [SW-1:0] set_s1;
	logic [3:0]    way_s1;
	logic [63:0]   addr_s1;
	logic          hit_s1;
	logic [4:0]    draw_s1;

	logic       out_valid_q;
	logic [3:0] victim_q;
	logic       stream_q;

	logic [SW-1:0] in_set;
	logic [12:0]   fold;
	logic          in_accept;
	logic          finish;

	// Sets beyond the table fold back onto it. The set field is below eight
	// times the smallest table, so three compare-and-subtract steps suffice.
	always_comb begin
		fold = {2'b00, set_index};
		if (NUM_SETS < 2048) begin
			for (int k = 2; k >= 0; k--) begin
				if (fold >= 13'(NUM_SETS << k)) fold = fold - 13'(NUM_SETS << k);
			end
		end
		in_set = SW'(fold);
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign finish    = (state_q == ST_WORK) && (!out_valid_q || !out_stall);

	// Victim search and ageing.
	logic          any_dead;
	logic [3:0]    dead_way;
	logic [1:0]    top;
	logic [1:0]    lift;
	logic [3:0]    top_way;
	logic          top_found;
	rrv_row_t      aged_row;

	always_comb begin
		any_dead  = 1'b0;
		dead_way  = '0;
		top       = '0;
		top_way   = '0;
		top_found = 1'b0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (dead_s1[w]) begin
				any_dead = 1'b1;
				dead_way = 4'(w);
			end
		end
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (rrv_s1[w] > top) top = rrv_s1[w];
		end
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (rrv_s1[w] == top) begin
				top_found = 1'b1;
				top_way   = 4'(w);
			end
		end
		lift = RRV_MAX - top;
		for (int w = 0; w < NUM_WAYS; w++) begin
			aged_row[w] = rrv_s1[w] + lift;
		end
	end

	// Stream detector and insertion.
	logic [63:0] stride;
	logic [1:0]  new_count;
	logic        streaming;
	logic        srrip_lead;
	logic        brrip_lead;
	logic [1:0]  brrip_val;
	logic [1:0]  ins_val;
	rrv_row_t    upd_rrv;
	dead_row_t   upd_dead;
	set_rec_t    upd_rec;

	always_comb begin
		stride = addr_s1 - rec_s1.prev_address;
		if (rec_s1.prev_stride != 64'd0 && stride == rec_s1.prev_stride) begin
			new_count = (rec_s1.stream_count == CNT_MAX) ? CNT_MAX
				: rec_s1.stream_count + 2'd1;
		end else begin
			new_count = (rec_s1.stream_count == 2'd0) ? 2'd0
				: rec_s1.stream_count - 2'd1;
		end
		streaming  = (new_count >= CNT_STREAM);
		srrip_lead = (32'(set_s1) < 32'(LEADER_COUNT));
		brrip_lead = !srrip_lead && (32'(set_s1) >= 32'(NUM_SETS - LEADER_COUNT));
		brrip_val  = (draw_s1 == 5'd0) ? RRV_NEAR : RRV_MAX;
		if (streaming) begin
			ins_val = RRV_MAX;
		end else if (srrip_lead) begin
			ins_val = RRV_NEAR;
		end else if (brrip_lead) begin
			ins_val = brrip_val;
		end else begin
			ins_val = (sel_q >= SEL_MID) ? RRV_NEAR : brrip_val;
		end
		upd_rrv  = rrv_s1;
		upd_dead = dead_s1;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (32'(way_s1) == w) begin
				upd_rrv[w]  = hit_s1 ? RRV_HIT : ins_val;
				upd_dead[w] = !hit_s1 && streaming;
			end
		end
		upd_rec.prev_address = addr_s1;
		upd_rec.prev_stride  = stride;
		upd_rec.stream_count = new_count;
	end

	// Memory write port: clearing pass or write-back of the working beat.
	logic          wr_en;
	logic [SW-1:0] wr_addr;
	rrv_row_t      wr_rrv;
	dead_row_t     wr_dead;
	set_rec_t      wr_rec;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = set_s1;
		wr_rrv  = rrv_s1;
		wr_dead = dead_s1;
		wr_rec  = rec_s1;
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_rrv  = {NUM_WAYS{RRV_MAX}};
			wr_dead = '0;
			wr_rec  = '0;
		end else if (finish) begin
			wr_en = 1'b1;
			if (act_s1 == ACT_VICTIM) begin
				if (!any_dead) wr_rrv = aged_row;
			end else begin
				wr_rrv  = upd_rrv;
				wr_dead = upd_dead;
				wr_rec  = upd_rec;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rrv_mem[wr_addr]  <= wr_rrv;
			dead_mem[wr_addr] <= wr_dead;
			set_mem[wr_addr]  <= wr_rec;
		end
		if (in_accept) begin
			rrv_s1  <= rrv_mem[in_set];
			dead_s1 <= dead_mem[in_set];
			rec_s1  <= set_mem[in_set];
			act_s1  <= action;
			set_s1  <= in_set;
			way_s1  <= way;
			addr_s1 <= address;
			hit_s1  <= hit;
			draw_s1 <= random_draw;
		end
		if (finish) begin
			if (act_s1 == ACT_VICTIM) begin
				victim_q <= any_dead ? dead_way : (top_found ? top_way : 4'd0);
				stream_q <= 1'b0;
			end else begin
				victim_q <= 4'd0;
				stream_q <= streaming;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			sel_q       <= SEL_MID;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == NUM_SETS - 1) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_accept) state_q <= ST_WORK;
				end
				ST_WORK: begin
					if (finish) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (finish && act_s1 == ACT_UPDATE && !hit_s1) begin
				if (brrip_lead && sel_q != 10'd0) begin
					sel_q <= sel_q - 10'd1;
				end else if (srrip_lead && sel_q != SEL_MAX) begin
					sel_q <= sel_q + 10'd1;
				end
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign victim_way      = victim_q;
	assign stream_detected = stream_q;

	a_accept_to_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> state_q == ST_WORK)
		else $error("accepted beat did not enter work");
	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> out_valid_q)
		else $error("finished beat not presented");
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !in_accept && !out_valid_q)
		else $error("activity during clearing pass");
	a_victim_upd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && act_s1 == ACT_UPDATE) |=> victim_q == 4'd0)
		else $error("update returned a victim");

endmodule
`default_nettype wire

// File: sim/drrip_stream_dead_block_replacement_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drrip_stream_dead_block_replacement_checker
// Watches both channels of the replacement engine, predicts every result from
// its own copy of the line and set state, and counts field mismatches.
// ----------------------------------------------------------------------------
module drrip_stream_dead_block_replacement_checker #(
	parameter int NUM_SETS     = 2048,
	parameter int NUM_WAYS     = 16,
	parameter int LEADER_COUNT = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic        action,
	input  wire logic [10:0] set_index,
	input  wire logic [3:0]  way,
	input  wire logic [63:0] address,
	input  wire logic        hit,
	input  wire logic [4:0]  random_draw,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [3:0]  victim_way,
	input  wire logic        stream_detected,
	output int               fail_count,
	output int               pending_count
);
	import drrip_pkg::*;

	typedef struct packed {
		logic [3:0] victim_way;
		logic       stream_detected;
	} replace_res_t;

	logic [1:0]  line_rrv  [NUM_SETS*NUM_WAYS];
	logic        line_dead [NUM_SETS*NUM_WAYS];
	logic [63:0] seen_addr [NUM_SETS];
	logic [63:0] last_stride [NUM_SETS];
	logic [1:0]  run_count [NUM_SETS];
	logic [9:0]  duel_sel;
	replace_res_t expected_q[$];

	assign pending_count = expected_q.size();

	function automatic logic [1:0] brrip_insert(logic [4:0] draw);
		return (draw == 5'd0) ? RRV_NEAR : RRV_MAX;
	endfunction

	function automatic replace_res_t predict_access(logic act, logic [10:0] si,
			logic [3:0] wy, logic [63:0] addr, logic ht, logic [4:0] draw);
		replace_res_t r;
		int s, base, idx;
		logic [63:0] stride;
		logic [1:0] top, ins;
		logic streaming, srrip_lead, brrip_lead, in_range, found;
		s = int'(si) % NUM_SETS;
		base = s * NUM_WAYS;
		srrip_lead = s < LEADER_COUNT;
		brrip_lead = !srrip_lead && s >= NUM_SETS - LEADER_COUNT;
		in_range = int'(wy) < NUM_WAYS;
		idx = base + (in_range ? int'(wy) : 0);
		r = '0;
		if (act == ACT_VICTIM) begin
			found = 1'b0;
			for (int w = 0; w < NUM_WAYS; w++)
				if (!found && line_dead[base+w]) begin
					r.victim_way = 4'(w);
					found = 1'b1;
				end
			if (!found) begin
				top = 2'd0;
				for (int w = 0; w < NUM_WAYS; w++)
					if (line_rrv[base+w] > top) top = line_rrv[base+w];
				for (int w = 0; w < NUM_WAYS; w++)
					line_rrv[base+w] = line_rrv[base+w] + (RRV_MAX - top);
				for (int w = 0; w < NUM_WAYS; w++)
					if (!found && line_rrv[base+w] == RRV_MAX) begin
						r.victim_way = 4'(w);
						found = 1'b1;
					end
			end
			return r;
		end
		stride = addr - seen_addr[s];
		if (last_stride[s] != 64'd0 && stride == last_stride[s]) begin
			if (run_count[s] < CNT_MAX) run_count[s]++;
		end else if (run_count[s] > 2'd0) begin
			run_count[s]--;
		end
		last_stride[s] = stride;
		seen_addr[s] = addr;
		streaming = run_count[s] >= CNT_STREAM;
		r.stream_detected = streaming;
		if (ht) begin
			if (in_range) begin
				line_rrv[idx] = RRV_HIT;
				line_dead[idx] = 1'b0;
			end
			return r;
		end
		if (streaming) ins = RRV_MAX;
		else if (srrip_lead) ins = RRV_NEAR;
		else if (brrip_lead) ins = brrip_insert(draw);
		else ins = (duel_sel >= SEL_MID) ? RRV_NEAR : brrip_insert(draw);
		if (in_range) begin
			line_rrv[idx] = ins;
			line_dead[idx] = streaming;
		end
		if (brrip_lead) begin
			if (duel_sel > 10'd0) duel_sel--;
		end else if (srrip_lead) begin
			if (duel_sel < SEL_MAX) duel_sel++;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		replace_res_t exp_r;
		if (!arst_n) begin
			for (int i = 0; i < NUM_SETS*NUM_WAYS; i++) begin
				line_rrv[i] = RRV_MAX;
				line_dead[i] = 1'b0;
			end
			for (int i = 0; i < NUM_SETS; i++) begin
				seen_addr[i] = '0;
				last_stride[i] = '0;
				run_count[i] = '0;
			end
			duel_sel = SEL_MID;
			fail_count = 0;
			expected_q.delete();
		end else begin
			// The result check comes first so a beat accepted this edge can
			// never be matched against a result in the same cycle.
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result victim_way=%0d stream_detected=%0d",
						$time, victim_way, stream_detected);
					fail_count++;
				end else begin
					exp_r = expected_q.pop_front();
					if (victim_way !== exp_r.victim_way) begin
						$display("%0t: victim_way expected %0d actual %0d",
							$time, exp_r.victim_way, victim_way);
						fail_count++;
					end
					if (stream_detected !== exp_r.stream_detected) begin
						$display("%0t: stream_detected expected %0d actual %0d",
							$time, exp_r.stream_detected, stream_detected);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				expected_q.push_back(predict_access(action, set_index, way, address,
					hit, random_draw));
		end
	end

endmodule

// File: sim/drrip_stream_dead_block_replacement_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drrip_stream_dead_block_replacement_top_tb
// Drives directed and random victim requests and updates through the engine
// under several idle and stall mixes; the checker predicts and compares.
// ----------------------------------------------------------------------------
module drrip_stream_dead_block_replacement_top_tb;
	import drrip_pkg::*;

	localparam int NUM_SETS  = 2048;
	localparam int CYCLE_CAP = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        action = ACT_VICTIM;
	logic [10:0] set_index = '0;
	logic [3:0]  way = '0;
	logic [63:0] address = '0;
	logic        hit = 1'b0;
	logic [4:0]  random_draw = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  victim_way;
	logic        stream_detected;
	int          fail_count, pending_count;
	int          idle_pct = 0, stall_pct = 0, hold_cycles = 0;
	int          cycle_count = 0;
	bit          hold_go = 1'b0;
	bit          hold_taken = 1'b0;
	logic [63:0] stream_base [4];
	logic [63:0] stream_step [4];
	logic [10:0] stream_set  [4];

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	drrip_stream_dead_block_replacement_top u_top (.*);

	drrip_stream_dead_block_replacement_checker u_chk (.*);

	// Receiver: random stall, or a long hold-off while hold_cycles runs down.
	always @(negedge clk) begin
		if (hold_go && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_cycles <= 200;
			out_stall <= 1'b1;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_CAP) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send_beat(logic act, logic [10:0] si, logic [3:0] wy,
			logic [63:0] addr, logic ht, logic [4:0] draw);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		set_index <= si;
		way <= wy;
		address <= addr;
		hit <= ht;
		random_draw <= draw;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// Sets are drawn mostly from the two leader groups and a few followers so
	// that lines get revisited and the stride detector sees repeats.
	function automatic logic [10:0] pick_set();
		case ($urandom_range(3))
			0: return 11'($urandom_range(3));
			1: return 11'(NUM_SETS - 1 - $urandom_range(3));
			2: return 11'(1000 + $urandom_range(3));
			default: return 11'($urandom);
		endcase
	endfunction

	task automatic random_beat();
		int k;
		if ($urandom_range(99) < 60) begin
			// Strided stream on one of a few tracked sets.
			k = $urandom_range(3);
			stream_base[k] = stream_base[k] + stream_step[k];
			send_beat(ACT_UPDATE, stream_set[k], 4'($urandom), stream_base[k],
				$urandom_range(1), 5'($urandom));
			if ($urandom_range(3) == 0)
				send_beat(ACT_VICTIM, stream_set[k], 4'($urandom), {$urandom, $urandom},
					1'($urandom), 5'($urandom));
		end else begin
			send_beat(1'($urandom), pick_set(), 4'($urandom), {$urandom, $urandom},
				1'($urandom), 5'($urandom_range(2) == 0 ? 0 : $urandom));
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		for (int k = 0; k < 4; k++) begin
			stream_set[k]  = pick_set();
			stream_base[k] = {$urandom, $urandom};
			stream_step[k] = 64'($urandom_range(1, 256)) << 6;
		end
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes, both actions, streaming, BRRIP rare insert.
		send_beat(ACT_VICTIM, 11'd0, 4'd0, 64'd0, 1'b0, 5'd0);
		send_beat(ACT_VICTIM, 11'h7FF, 4'hF, '1, 1'b1, 5'h1F);
		for (int i = 1; i <= 4; i++)
			send_beat(ACT_UPDATE, 11'd5, 4'(i), 64'(i * 64), 1'b0, 5'd7);
		send_beat(ACT_VICTIM, 11'd5, 4'd0, '0, 1'b0, 5'd0);
		send_beat(ACT_UPDATE, 11'd5, 4'd2, 64'd320, 1'b1, 5'd0);
		send_beat(ACT_UPDATE, 11'h7FF, 4'd3, '1, 1'b0, 5'd0);
		send_beat(ACT_UPDATE, 11'h7FF, 4'd4, 64'd9, 1'b0, 5'h1F);
		send_beat(ACT_UPDATE, 11'd1000, 4'hF, 64'd0, 1'b0, 5'd0);
		send_beat(ACT_UPDATE, 11'd1000, 4'd0, 64'hFFFF_FFFF_0000_0000, 1'b1, 5'd1);
		send_beat(ACT_VICTIM, 11'd1000, 4'd0, '0, 1'b0, 5'd0);
		send_beat(ACT_UPDATE, 11'd63, 4'd1, 64'h8000_0000_0000_0000, 1'b0, 5'd3);
		send_beat(ACT_UPDATE, 11'd64, 4'd1, 64'h1, 1'b0, 5'd3);
		send_beat(ACT_UPDATE, 11'd1983, 4'd1, 64'h2, 1'b0, 5'd0);
		send_beat(ACT_UPDATE, 11'd1984, 4'd1, 64'h3, 1'b0, 5'd0);
		send_beat(ACT_VICTIM, 11'd1984, 4'd0, '0, 1'b0, 5'd0);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 63; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 63; end
				default: begin idle_pct = 26; stall_pct = 26; end
			endcase
			if (ph == 2) hold_go = 1'b1;
			repeat (100) random_beat();
			drain();
		end
		idle_pct = 0;
		stall_pct = 0;
		repeat (40) random_beat();
		drain();
		repeat (20) @(negedge clk);
		if (fail_count == 0 && pending_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
